// ----- design/ojt_pkg.sv -----
// ----------------------------------------------------------------------------
// ojt_pkg
// Shared types, field widths and codes of the ordered job table.
// ----------------------------------------------------------------------------
`default_nettype none

package ojt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned KEY_W    = 22;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REM_POS  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REM_KEY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_POS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND_KEY = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    proc_id;
    logic [POS_W-1:0]    position;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [KEY_W-1:0]    out_proc_id;
    logic [COUNT_W-1:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } entry_t;

endpackage

`default_nettype wire

// ----- design/ordered_job_table_core.sv -----
// ----------------------------------------------------------------------------
// ordered_job_table_core
// Compact ordered job table with append, remove, read and search by id.
// ----------------------------------------------------------------------------
// One command per input transaction (in_valid_i / in_stall_o), one result per
// output transaction (out_valid_o / out_stall_i), held in an output register.
// Commands are taken one at a time; in_stall_o is high while one is in work.
// The entries live in a single-port-read, single-port-write RAM with
// registered read data; searches and compaction walk it one entry per cycle.
// Append, a bad position, an unused kind and a search of an empty table go
// straight to the result; a read fetches one entry; a remove at a position
// fetches it, then shifts each later entry down one slot; a find scans from
// slot zero up to the first match or the count; a remove by id scans, then
// shifts. The longest commands are a search that misses, a remove by id or
// a remove of the first entry, on a full table.
// A new command is taken as soon as the previous result is in the output
// register, even if the receiver stalls it; a finished result waits there
// until the output register frees. Reset empties the table (count zero);
// no clearing pass is needed since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_job_table_core
  import ojt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [KEY_W-1:0] key_q, key_d;
  out_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;

  logic start_shift;
  logic [AW-1:0] shift_slot;
  logic out_free;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic pos_ok, tbl_full;
  logic [AW-1:0] pos_slot;

  ojt_ram #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(ram_waddr),
    .wr_data_i(ram_wdata),
    .rd_en_i  (ram_re),
    .rd_addr_i(ram_raddr),
    .rd_data_o(ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign pos_ext  = CMPW'(in_data_i.position);
  assign cnt_ext  = CMPW'(count_q);
  assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_slot = AW'(pos_ext - CMPW'(1));
  assign tbl_full = (count_q == CW'(TABLE_DEPTH));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    kind_d      = kind_q;
    key_d       = key_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = '0;
    ram_wdata   = ram_rdata;
    start_shift = 1'b0;
    shift_slot  = ptr_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_data_i.kind;
          key_d   = in_data_i.proc_id;
          res_d   = '{status: STATUS_MISS, default: '0};
          state_d = ST_RESP;
          case (in_data_i.kind)
            KIND_APPEND: begin
              if (tbl_full) begin
                res_d.status = STATUS_FULL;
              end else begin
                ram_we       = 1'b1;
                ram_waddr    = AW'(count_q);
                ram_wdata    = '{handle: in_data_i.handle, key: in_data_i.proc_id};
                count_d      = count_q + CW'(1);
                res_d.status = STATUS_OK;
              end
            end
            KIND_REM_POS, KIND_READ_POS: begin
              if (pos_ok) begin
                ram_re    = 1'b1;
                ram_raddr = pos_slot;
                ptr_d     = pos_slot;
                state_d   = ST_FETCH;
              end
            end
            KIND_REM_KEY, KIND_FIND_KEY: begin
              if (count_q != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_d     = '0;
                state_d   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        res_d = '{status: STATUS_OK, out_handle: ram_rdata.handle,
                  out_proc_id: ram_rdata.key, entry_count: '0};
        if (kind_q == KIND_REM_POS) begin
          start_shift = 1'b1;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (ram_rdata.key == key_q) begin
          res_d = '{status: STATUS_OK, out_handle: ram_rdata.handle,
                    out_proc_id: ram_rdata.key, entry_count: '0};
          if (kind_q == KIND_REM_KEY) begin
            start_shift = 1'b1;
          end else begin
            state_d = ST_RESP;
          end
        end else if (CW'(ptr_q) + CW'(1) == count_q) begin
          state_d = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        if (CW'(ptr_q) + CW'(2) == count_q) begin
          count_d = count_q - CW'(1);
          state_d = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AW'(1) + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (start_shift) begin
      if (CW'(shift_slot) + CW'(1) == count_q) begin
        count_d = count_q - CW'(1);
        state_d = ST_RESP;
      end else begin
        ram_re    = 1'b1;
        ram_raddr = shift_slot + AW'(1);
        ptr_d     = shift_slot;
        state_d   = ST_SHIFT;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_RESP) && out_free) begin
      out_valid_d       = 1'b1;
      out_d             = res_q;
      out_d.entry_count = COUNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    kind_q <= kind_d;
    key_q  <= key_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- design/ojt_ram.sv -----
// ----------------------------------------------------------------------------
// ojt_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ojt_ram
  import ojt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire entry_t        wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output entry_t             rd_data_o
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- test/ojt_result_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ojt_result_check
// Watches both channels of the ordered job table, predicts every result from
// its own copy of the table and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ojt_result_check
  import ojt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_stall_i,
  input  wire in_t  in_data_i,
  input  wire logic out_valid_i,
  input  wire logic out_stall_i,
  input  wire out_t out_data_i,
  output int        error_count_o,
  output int        pending_o
);

  entry_t job_entries [TABLE_DEPTH];
  int     job_count;
  out_t   expected_results [$];
  int     mismatches;

  function automatic out_t run_job_cmd(in_t cmd);
    out_t res;
    int   slot;
    int   idx;
    res        = '0;
    res.status = STATUS_MISS;
    slot       = -1;
    case (cmd.kind)
      KIND_APPEND: begin
        if (job_count >= TABLE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          job_entries[job_count].handle = cmd.handle;
          job_entries[job_count].key    = cmd.proc_id;
          job_count++;
          res.status = STATUS_OK;
        end
      end
      KIND_REM_POS, KIND_READ_POS: begin
        if (int'(cmd.position) >= 1 && int'(cmd.position) <= job_count)
          slot = int'(cmd.position) - 1;
      end
      KIND_REM_KEY, KIND_FIND_KEY: begin
        // scan downward so the lowest match wins
        for (idx = job_count - 1; idx >= 0; idx--)
          if (job_entries[idx].key == cmd.proc_id) slot = idx;
      end
      default: ;
    endcase
    if (slot >= 0) begin
      res.status      = STATUS_OK;
      res.out_handle  = job_entries[slot].handle;
      res.out_proc_id = job_entries[slot].key;
      if (cmd.kind == KIND_REM_POS || cmd.kind == KIND_REM_KEY) begin
        for (idx = slot; idx < job_count - 1; idx++)
          job_entries[idx] = job_entries[idx + 1];
        job_count--;
      end
    end
    res.entry_count = COUNT_W'(job_count);
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, actual %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      job_count = 0;
      expected_results.delete();
      mismatches    = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected transaction", '0, 64'(out_data_i));
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status !== want.status)
            flag_mismatch("status", 64'(want.status), 64'(out_data_i.status));
          if (out_data_i.out_handle !== want.out_handle)
            flag_mismatch("out_handle", 64'(want.out_handle), 64'(out_data_i.out_handle));
          if (out_data_i.out_proc_id !== want.out_proc_id)
            flag_mismatch("out_proc_id", 64'(want.out_proc_id), 64'(out_data_i.out_proc_id));
          if (out_data_i.entry_count !== want.entry_count)
            flag_mismatch("entry_count", 64'(want.entry_count), 64'(out_data_i.entry_count));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(run_job_cmd(in_data_i));
      error_count_o <= mismatches;
      pending_o     <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_ordered_job_table_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_job_table_core
// Drives directed and phased random job commands into the ordered job table
// with random gaps and stalls on both sides, plus one long output hold-off,
// and reports the verdict from the result checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ordered_job_table_core;
  import ojt_pkg::*;

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
  localparam int          PHASES       = 11;
  localparam int          PHASE_JOBS   = 100;
  localparam int          HOLD_AT      = 150;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          IDLE_LIMIT   = 3000;
  localparam int          DRAIN_CYCLES = 300;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef enum int {PHASE_FILL, PHASE_MIXED, PHASE_DRAIN} phase_e;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  cmd_data  = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t result_data;

  int fail_count;
  int pending;
  int send_gap_max  = 0;
  int recv_gap_max  = 0;
  int results_taken = 0;
  int idle_cycles   = 0;
  int fill_guess    = 0;
  logic [KEY_W-1:0] key_pool [16];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ordered_job_table_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (cmd_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (result_data)
  );

  ojt_result_check #(.TABLE_DEPTH(DEPTH)) result_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (cmd_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (result_data),
    .error_count_o (fail_count),
    .pending_o     (pending)
  );

  function automatic in_t job_cmd(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
                                  logic [KEY_W-1:0] key, logic [POS_W-1:0] pos);
    in_t cmd;
    cmd.kind     = kind;
    cmd.handle   = handle;
    cmd.proc_id  = key;
    cmd.position = pos;
    return cmd;
  endfunction

  function automatic in_t random_job_cmd(phase_e phase);
    in_t cmd;
    int  r;
    r = $urandom_range(0, 99);
    case (phase)
      PHASE_FILL:
        cmd.kind = (r < 80) ? KIND_APPEND : (r < 85) ? KIND_REM_POS : (r < 89) ? KIND_REM_KEY :
                   (r < 94) ? KIND_READ_POS : (r < 98) ? KIND_FIND_KEY : KIND_SPARE_LO;
      PHASE_DRAIN:
        cmd.kind = (r < 10) ? KIND_APPEND : (r < 45) ? KIND_REM_POS : (r < 75) ? KIND_REM_KEY :
                   (r < 87) ? KIND_READ_POS : (r < 97) ? KIND_FIND_KEY : KIND_SPARE_LO;
      default:
        cmd.kind = (r < 35) ? KIND_APPEND : (r < 50) ? KIND_REM_POS : (r < 62) ? KIND_REM_KEY :
                   (r < 78) ? KIND_READ_POS : (r < 94) ? KIND_FIND_KEY : KIND_SPARE_LO;
    endcase
    if (cmd.kind == KIND_SPARE_LO)
      cmd.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    r = $urandom_range(0, 19);
    cmd.handle  = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
    cmd.proc_id = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(0, 15)];
    if ($urandom_range(0, 4) != 0)
      cmd.position = POS_W'($urandom_range(1, (fill_guess > 0) ? fill_guess : 1));
    else
      cmd.position = POS_W'($urandom);
    return cmd;
  endfunction

  task automatic send_job(in_t cmd);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd_data <= cmd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (cmd.kind == KIND_APPEND && fill_guess < DEPTH) fill_guess++;
    if ((cmd.kind == KIND_REM_POS || cmd.kind == KIND_REM_KEY) && fill_guess > 0) fill_guess--;
  endtask

  // result side, with one long hold-off so the block backs up
  initial begin : result_sink
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = (results_taken == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, recv_gap_max);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int p;
    int n;
    int k;
    for (k = 0; k < 16; k++) key_pool[k] = KEY_W'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table
    send_job(job_cmd(KIND_READ_POS, '0, '0, 7'd1));
    send_job(job_cmd(KIND_FIND_KEY, '0, '0, '0));
    send_job(job_cmd(KIND_REM_KEY, '0, '0, '0));
    send_job(job_cmd(KIND_REM_POS, '0, '0, 7'd1));
    // extremes and a duplicate id
    send_job(job_cmd(KIND_APPEND, '0, '0, '0));
    send_job(job_cmd(KIND_APPEND, '1, '1, '1));
    send_job(job_cmd(KIND_APPEND, 32'h1234_5678, '1, '0));
    send_job(job_cmd(KIND_READ_POS, '1, '1, 7'd0));
    send_job(job_cmd(KIND_READ_POS, '0, '0, 7'd2));
    send_job(job_cmd(KIND_READ_POS, '0, '0, 7'd3));
    send_job(job_cmd(KIND_READ_POS, '0, '0, 7'd4));
    send_job(job_cmd(KIND_READ_POS, '0, '0, '1));
    send_job(job_cmd(KIND_FIND_KEY, '0, '1, '0));
    send_job(job_cmd(KIND_FIND_KEY, '0, '0, '0));
    send_job(job_cmd(KIND_FIND_KEY, '0, 22'd1, '0));
    for (k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      send_job(job_cmd(KIND_W'(k), '1, '1, '1));
    send_job(job_cmd(KIND_REM_POS, '0, '0, 7'd1));
    send_job(job_cmd(KIND_REM_KEY, '0, '1, '0));
    send_job(job_cmd(KIND_READ_POS, '0, '0, 7'd1));
    send_job(job_cmd(KIND_REM_POS, '0, '0, 7'd1));
    send_job(job_cmd(KIND_REM_POS, '0, '0, 7'd1));

    for (p = 0; p < PHASES; p++) begin
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      for (n = 0; n < PHASE_JOBS; n++)
        send_job(random_job_cmd(phase_e'(p % 3)));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
